// File: rtl/rbs_pkg.sv
`default_nettype none
package rbs_pkg;

  localparam int DIV_STEPS = 32;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CFG_BOX_MIN_X    = 3'd0,
    CFG_BOX_MIN_Y    = 3'd1,
    CFG_BOX_MIN_Z    = 3'd2,
    CFG_BOX_MAX_X    = 3'd3,
    CFG_BOX_MAX_Y    = 3'd4,
    CFG_BOX_MAX_Z    = 3'd5,
    CFG_MIN_DISTANCE = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] FACE_NX = 3'd0;
  localparam logic [2:0] FACE_NY = 3'd1;
  localparam logic [2:0] FACE_NZ = 3'd2;
  localparam logic [2:0] FACE_PX = 3'd3;
  localparam logic [2:0] FACE_PY = 3'd4;
  localparam logic [2:0] FACE_PZ = 3'd5;

  // One step of the reciprocal divider.
  typedef struct packed {
    logic [31:0] mag;
    logic [31:0] rem;
    logic [31:0] quo;
    logic        neg;
    logic        zero;
    logic        one;
  } div_stage_t;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
  } ray_pl_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] t_value;
    logic [2:0]  face;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
  } result_t;

  function automatic q_t sat49(input logic signed [48:0] x);
    q_t r;
    if (x > 49'sd2147483647) begin
      r = Q_MAX;
    end else if (x < -49'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rbs_ray_if.sv
`default_nettype none
interface rbs_ray_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] dir_x;
  logic [31:0] dir_y;
  logic [31:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rbs_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] t_value;
  logic [2:0]  face;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;

  modport source (output valid, hit, t_value, face, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, hit, t_value, face, point_x, point_y, point_z,
                output ready);
endinterface
`default_nettype wire

// File: rtl/rbs_recip.sv
`default_nettype none
module rbs_recip (
  input  wire logic       clk,
  input  wire logic       adv,
  input  wire logic [31:0] dir,
  output rbs_pkg::q_t     recip
);
  rbs_pkg::div_stage_t st  [0:rbs_pkg::DIV_STEPS];
  rbs_pkg::div_stage_t nxt [1:rbs_pkg::DIV_STEPS];
  rbs_pkg::div_stage_t init;
  logic [32:0] sh [1:rbs_pkg::DIV_STEPS];
  logic [32:0] df [1:rbs_pkg::DIV_STEPS];

  always_comb begin
    init.neg  = dir[31];
    init.mag  = dir[31] ? (~dir + 32'd1) : dir;
    init.zero = (dir == 32'd0);
    init.one  = (init.mag == 32'd1);
    init.rem  = 32'd1;
    init.quo  = 32'd0;
  end

  // Restoring division of 2^32 by the magnitude, one quotient bit per stage.
  always_comb begin
    for (int k = 1; k <= rbs_pkg::DIV_STEPS; k++) begin
      sh[k] = {st[k-1].rem, 1'b0};
      df[k] = sh[k] - {1'b0, st[k-1].mag};
      nxt[k] = st[k-1];
      if (sh[k] >= {1'b0, st[k-1].mag}) begin
        nxt[k].rem = df[k][31:0];
        nxt[k].quo = {st[k-1].quo[30:0], 1'b1};
      end else begin
        nxt[k].rem = sh[k][31:0];
        nxt[k].quo = {st[k-1].quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= init;
      for (int k = 1; k <= rbs_pkg::DIV_STEPS; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  always_comb begin
    if (st[rbs_pkg::DIV_STEPS].zero) begin
      recip = rbs_pkg::Q_MAX;
    end else if (st[rbs_pkg::DIV_STEPS].one) begin
      recip = st[rbs_pkg::DIV_STEPS].neg ? rbs_pkg::Q_MIN : rbs_pkg::Q_MAX;
    end else if (st[rbs_pkg::DIV_STEPS].neg) begin
      recip = -$signed(st[rbs_pkg::DIV_STEPS].quo);
    end else if (st[rbs_pkg::DIV_STEPS].quo[31]) begin
      recip = rbs_pkg::Q_MAX;
    end else begin
      recip = $signed(st[rbs_pkg::DIV_STEPS].quo);
    end
  end
endmodule
`default_nettype wire

// File: rtl/rbs_slab.sv
`default_nettype none
module rbs_slab (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire rbs_pkg::q_t recip,
  input  wire rbs_pkg::q_t org,
  input  wire rbs_pkg::q_t lo,
  input  wire rbs_pkg::q_t hi,
  output rbs_pkg::q_t      tn,
  output rbs_pkg::q_t      tx,
  output logic             pos
);
  rbs_pkg::q_t         r_a;
  logic signed [32:0]  dlo_a;
  logic signed [32:0]  dhi_a;
  logic signed [64:0]  plo_b;
  logic signed [64:0]  phi_b;
  logic                pos_b;
  rbs_pkg::q_t         a_c;
  rbs_pkg::q_t         b_c;

  assign a_c = rbs_pkg::sat49(plo_b[64:16]);
  assign b_c = rbs_pkg::sat49(phi_b[64:16]);

  always_ff @(posedge clk) begin
    if (adv) begin
      r_a   <= recip;
      dlo_a <= 33'(lo) - 33'(org);
      dhi_a <= 33'(hi) - 33'(org);
      plo_b <= dlo_a * 65'(r_a);
      phi_b <= dhi_a * 65'(r_a);
      pos_b <= ~r_a[31];
      pos   <= pos_b;
      tn    <= pos_b ? a_c : b_c;
      tx    <= pos_b ? b_c : a_c;
    end
  end
endmodule
`default_nettype wire

// File: rtl/rbs_hit.sv
`default_nettype none
module rbs_hit (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire rbs_pkg::q_t      tn  [3],
  input  wire rbs_pkg::q_t      tx  [3],
  input  wire logic [2:0]       pos,
  input  wire rbs_pkg::ray_pl_t ray,
  input  wire logic [15:0]      eps,
  output rbs_pkg::result_t      res
);
  rbs_pkg::q_t      t0, t1, t0_d, t1_d, t_e, t_f;
  logic [2:0]       fin, fout, fin_d, fout_d, face_e, face_f;
  logic             hit_e, hit_f;
  rbs_pkg::ray_pl_t ray_d, ray_e, ray_f;
  logic signed [63:0] prod_f [3];
  rbs_pkg::q_t      eps_s;
  rbs_pkg::q_t      pt [3];

  assign eps_s = $signed({16'd0, eps});

  always_comb begin
    if (tn[0] > tn[1]) begin
      t0 = tn[0]; fin = pos[0] ? rbs_pkg::FACE_NX : rbs_pkg::FACE_PX;
    end else begin
      t0 = tn[1]; fin = pos[1] ? rbs_pkg::FACE_NY : rbs_pkg::FACE_PY;
    end
    if (tn[2] > t0) begin
      t0 = tn[2]; fin = pos[2] ? rbs_pkg::FACE_NZ : rbs_pkg::FACE_PZ;
    end
    if (tx[0] < tx[1]) begin
      t1 = tx[0]; fout = pos[0] ? rbs_pkg::FACE_PX : rbs_pkg::FACE_NX;
    end else begin
      t1 = tx[1]; fout = pos[1] ? rbs_pkg::FACE_PY : rbs_pkg::FACE_NY;
    end
    if (tx[2] < t1) begin
      t1 = tx[2]; fout = pos[2] ? rbs_pkg::FACE_PZ : rbs_pkg::FACE_NZ;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_d   <= t0;
      t1_d   <= t1;
      fin_d  <= fin;
      fout_d <= fout;
      ray_d  <= ray;
      hit_e  <= (t0_d < t1_d) && (t1_d > eps_s);
      t_e    <= (t0_d > eps_s) ? t0_d : t1_d;
      face_e <= (t0_d > eps_s) ? fin_d : fout_d;
      ray_e  <= ray_d;
      hit_f  <= hit_e;
      t_f    <= t_e;
      face_f <= face_e;
      ray_f  <= ray_e;
      for (int i = 0; i < 3; i++) begin
        prod_f[i] <= 64'(t_e) * 64'($signed(ray_e.dir[i]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = rbs_pkg::sat49(49'($signed(ray_f.org[i])) + 49'($signed(prod_f[i][63:16])));
    end
    res = '0;
    if (hit_f) begin
      res.hit     = 1'b1;
      res.t_value = t_f[30:0];
      res.face    = face_f;
      res.point_x = pt[0];
      res.point_y = pt[1];
      res.point_z = pt[2];
    end
  end
endmodule
`default_nettype wire

// File: rtl/ray_box_slab_intersect.sv
`default_nettype none
// Channel   Role     Transaction carries
// ray       sink     origin_x/y/z, dir_x/y/z (signed Q16.16)
// result    source   hit, t_value, face, point_x/y/z
// cfg_*     write    box corners and min_distance, by register index
//
// One ray is taken every cycle while result is not stalled; the result is offered
// after 40 register stages, counting the input register.
// The latency is set by the 32-stage reciprocal divider (one quotient bit
// per stage), followed by slab multiply, entry/exit select and hit point.
// Reset clears the valid bits and loads the default box and epsilon.
// A stall on result freezes the whole pipeline; nothing is dropped or doubled.
module ray_box_slab_intersect (
  input  wire logic        clk,
  input  wire logic        rst,
  rbs_ray_if.sink          ray,
  rbs_hit_if.source        result,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  localparam int SLAB_TAP = rbs_pkg::DIV_STEPS;
  localparam int HIT_TAP  = SLAB_TAP + 3;
  localparam int VLD_LEN  = HIT_TAP + 4;

  rbs_pkg::q_t      box_lo [3];
  rbs_pkg::q_t      box_hi [3];
  logic [15:0]      min_distance;
  logic             adv;
  logic [VLD_LEN-1:0] vld;
  rbs_pkg::ray_pl_t dl [0:HIT_TAP];
  rbs_pkg::ray_pl_t ray_in;
  rbs_pkg::q_t      recip [3];
  rbs_pkg::q_t      tn [3];
  rbs_pkg::q_t      tx [3];
  logic [2:0]       pos;
  rbs_pkg::result_t res;

  assign adv       = !result.valid || result.ready;
  assign ray.ready = adv;

  assign ray_in.org = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign ray_in.dir = {ray.dir_z, ray.dir_y, ray.dir_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo       <= '{32'sd0, 32'sd0, 32'sd0};
      box_hi       <= '{32'sd65536, 32'sd65536, 32'sd65536};
      min_distance <= 16'd1;
    end else if (cfg_we) begin
      unique case (rbs_pkg::cfg_idx_t'(cfg_index))
        rbs_pkg::CFG_BOX_MIN_X:    box_lo[0]    <= cfg_wdata;
        rbs_pkg::CFG_BOX_MIN_Y:    box_lo[1]    <= cfg_wdata;
        rbs_pkg::CFG_BOX_MIN_Z:    box_lo[2]    <= cfg_wdata;
        rbs_pkg::CFG_BOX_MAX_X:    box_hi[0]    <= cfg_wdata;
        rbs_pkg::CFG_BOX_MAX_Y:    box_hi[1]    <= cfg_wdata;
        rbs_pkg::CFG_BOX_MAX_Z:    box_hi[2]    <= cfg_wdata;
        rbs_pkg::CFG_MIN_DISTANCE: min_distance <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[VLD_LEN-2:0], ray.valid};
      result.valid <= vld[VLD_LEN-1];
    end
  end

  // Ray payload rides alongside the divider and slab stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= ray_in;
      for (int k = 1; k <= HIT_TAP; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rbs_recip u_recip (
      .clk   (clk),
      .adv   (adv),
      .dir   (ray_in.dir[i]),
      .recip (recip[i])
    );
    rbs_slab u_slab (
      .clk   (clk),
      .adv   (adv),
      .recip (recip[i]),
      .org   ($signed(dl[SLAB_TAP].org[i])),
      .lo    (box_lo[i]),
      .hi    (box_hi[i]),
      .tn    (tn[i]),
      .tx    (tx[i]),
      .pos   (pos[i])
    );
  end

  rbs_hit u_hit (
    .clk (clk),
    .adv (adv),
    .tn  (tn),
    .tx  (tx),
    .pos (pos),
    .ray (dl[HIT_TAP]),
    .eps (min_distance),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      result.hit     <= res.hit;
      result.t_value <= res.t_value;
      result.face    <= res.face;
      result.point_x <= res.point_x;
      result.point_y <= res.point_y;
      result.point_z <= res.point_z;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.face <= 3'd5)
    else $error("face code out of range");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.hit |-> result.t_value == 31'd0 && result.face == 3'd0
      && result.point_x == 32'd0 && result.point_y == 32'd0 && result.point_z == 32'd0)
    else $error("miss carries nonzero fields");
  a_hit_beyond_eps: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hit |-> result.t_value > {15'd0, min_distance})
    else $error("hit distance not beyond epsilon");
endmodule
`default_nettype wire

// File: tb/sv/ray_box_slab_intersect_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect_tb;

  localparam int LATENCY = 40;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [30:0] t_value;
    logic [2:0]  face;
    logic [31:0] px, py, pz;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  rbs_ray_if ray ();
  rbs_hit_if result ();

  ray_box_slab_intersect i_dut (
    .clk(clk), .rst(rst), .ray(ray.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Box and epsilon as the predictor sees them.
  longint box_lo[3];
  longint box_hi[3];
  longint epsilon;

  ray_t   pending_rays[$];
  isect_t expected_hits[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     hold_count = 0;
  int     send_wait = 0;
  int     recv_wait = 0;
  bit     stim_done = 1'b0;

  function automatic longint sext(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint floor_q16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint inv_dir(longint d);
    if (d == 0) return 64'sd2147483647;
    return clamp32(64'sd4294967296 / d);
  endfunction

  function automatic isect_t slab_test(ray_t r);
    longint org[3], dir[3], tn[3], tx[3];
    bit     pos[3];
    longint rc, a, b, t0, t1, t, p;
    logic [2:0] fin, fout, fc;
    isect_t res;
    org[0] = sext(r.ox); org[1] = sext(r.oy); org[2] = sext(r.oz);
    dir[0] = sext(r.dx); dir[1] = sext(r.dy); dir[2] = sext(r.dz);
    for (int i = 0; i < 3; i++) begin
      rc = inv_dir(dir[i]);
      pos[i] = rc >= 0;
      a = clamp32(floor_q16((box_lo[i] - org[i]) * rc));
      b = clamp32(floor_q16((box_hi[i] - org[i]) * rc));
      tn[i] = pos[i] ? a : b;
      tx[i] = pos[i] ? b : a;
    end
    if (tn[0] > tn[1]) begin
      t0 = tn[0]; fin = pos[0] ? rbs_pkg::FACE_NX : rbs_pkg::FACE_PX;
    end else begin
      t0 = tn[1]; fin = pos[1] ? rbs_pkg::FACE_NY : rbs_pkg::FACE_PY;
    end
    if (tn[2] > t0) begin
      t0 = tn[2]; fin = pos[2] ? rbs_pkg::FACE_NZ : rbs_pkg::FACE_PZ;
    end
    if (tx[0] < tx[1]) begin
      t1 = tx[0]; fout = pos[0] ? rbs_pkg::FACE_PX : rbs_pkg::FACE_NX;
    end else begin
      t1 = tx[1]; fout = pos[1] ? rbs_pkg::FACE_PY : rbs_pkg::FACE_NY;
    end
    if (tx[2] < t1) begin
      t1 = tx[2]; fout = pos[2] ? rbs_pkg::FACE_PZ : rbs_pkg::FACE_NZ;
    end
    res = '{1'b0, '0, '0, '0, '0, '0};
    if (t0 < t1 && t1 > epsilon) begin
      if (t0 > epsilon) begin
        t = t0; fc = fin;
      end else begin
        t = t1; fc = fout;
      end
      res.hit = 1'b1;
      res.t_value = t[30:0];
      res.face = fc;
      p = clamp32(org[0] + floor_q16(t * dir[0])); res.px = p[31:0];
      p = clamp32(org[1] + floor_q16(t * dir[1])); res.py = p[31:0];
      p = clamp32(org[2] + floor_q16(t * dir[2])); res.pz = p[31:0];
    end
    return res;
  endfunction

  // Driver: one ray per transaction, with a random gap, possibly none, after each.
  initial begin
    ray.valid = 1'b0;
    {ray.origin_x, ray.origin_y, ray.origin_z} = '0;
    {ray.dir_x, ray.dir_y, ray.dir_z} = '0;
  end

  always @(posedge clk) begin
    logic take;
    int   w;
    if (!rst) begin
      take = ray.valid && ray.ready;
      w = 0;
      if (take) begin
        expected_hits.push_back(slab_test('{ray.origin_x, ray.origin_y, ray.origin_z,
                                            ray.dir_x, ray.dir_y, ray.dir_z}));
        void'(pending_rays.pop_front());
        w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (ray.valid && !take) begin
        // Still offering.
      end else if (take && w > 0) begin
        ray.valid <= 1'b0;
        send_wait <= w - 1;
      end else if (!take && send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_rays.size() > 0) begin
        ray.valid    <= 1'b1;
        ray.origin_x <= pending_rays[0].ox;
        ray.origin_y <= pending_rays[0].oy;
        ray.origin_z <= pending_rays[0].oz;
        ray.dir_x    <= pending_rays[0].dx;
        ray.dir_y    <= pending_rays[0].dy;
        ray.dir_z    <= pending_rays[0].dz;
      end else begin
        ray.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  initial result.ready = 1'b0;

  always @(posedge clk) begin
    isect_t e;
    int     w;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_hits.size() == 0) begin
          $error("result with no ray outstanding");
          errors++;
        end else begin
          e = expected_hits.pop_front();
          if (result.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, result.hit); errors++;
          end
          if (result.t_value !== e.t_value) begin
            $error("t_value: expected %0h, got %0h", e.t_value, result.t_value);
            errors++;
          end
          if (result.face !== e.face) begin
            $error("face: expected %0d, got %0d", e.face, result.face); errors++;
          end
          if (result.point_x !== e.px) begin
            $error("point_x: expected %0h, got %0h", e.px, result.point_x); errors++;
          end
          if (result.point_y !== e.py) begin
            $error("point_y: expected %0h, got %0h", e.py, result.point_y); errors++;
          end
          if (result.point_z !== e.pz) begin
            $error("point_z: expected %0h, got %0h", e.pz, result.point_z); errors++;
          end
        end
      end
      if (hold_count > 0) begin
        hold_count <= hold_count - 1;
        result.ready <= 1'b0;
      end else if (result.valid && result.ready) begin
        w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        recv_wait <= (w > 0) ? w - 1 : 0;
        result.ready <= (w == 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (ray.valid && ray.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (stim_done || pending_rays.size() > 0 || expected_hits.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(rbs_pkg::cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx) inside
      rbs_pkg::CFG_BOX_MIN_X, rbs_pkg::CFG_BOX_MIN_Y, rbs_pkg::CFG_BOX_MIN_Z:
        box_lo[idx] = sext(v);
      rbs_pkg::CFG_BOX_MAX_X, rbs_pkg::CFG_BOX_MAX_Y, rbs_pkg::CFG_BOX_MAX_Z:
        box_hi[idx - 3] = sext(v);
      default: epsilon = longint'(v[15:0]);
    endcase
  endtask

  task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz, logic [15:0] e);
    write_reg(rbs_pkg::CFG_BOX_MIN_X, lx);
    write_reg(rbs_pkg::CFG_BOX_MIN_Y, ly);
    write_reg(rbs_pkg::CFG_BOX_MIN_Z, lz);
    write_reg(rbs_pkg::CFG_BOX_MAX_X, hx);
    write_reg(rbs_pkg::CFG_BOX_MAX_Y, hy);
    write_reg(rbs_pkg::CFG_BOX_MAX_Z, hz);
    write_reg(rbs_pkg::CFG_MIN_DISTANCE, {16'd0, e});
  endtask

  task automatic drain;
    while (pending_rays.size() != 0 || expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
      2: return $urandom_range(0, 3) == 0 ? 32'h0 : 32'($urandom_range(0, 1 << 17)) - 32'h10000;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // Mostly rays aimed at the box from a few units away, so many of them hit.
  task automatic queue_random(int n);
    ray_t r;
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 9);
      if (m < 6) begin
        r.ox = rand_coord(1); r.oy = rand_coord(1); r.oz = rand_coord(1);
        r.dx = 32'h8000 - r.ox + 32'($urandom_range(0, 1 << 15)) - 32'h4000;
        r.dy = 32'h8000 - r.oy + 32'($urandom_range(0, 1 << 15)) - 32'h4000;
        r.dz = 32'h8000 - r.oz + 32'($urandom_range(0, 1 << 15)) - 32'h4000;
        if ($urandom_range(0, 7) == 0) r.dx = 0;
      end else if (m < 8) begin
        r.ox = rand_coord(1); r.oy = rand_coord(1); r.oz = rand_coord(1);
        r.dx = rand_coord(2); r.dy = rand_coord(2); r.dz = rand_coord(2);
      end else if (m == 8) begin
        r.ox = rand_coord(0); r.oy = rand_coord(0); r.oz = rand_coord(0);
        r.dx = rand_coord(0); r.dy = rand_coord(0); r.dz = rand_coord(0);
      end else begin
        r.ox = rand_coord(3); r.oy = rand_coord(0); r.oz = rand_coord(3);
        r.dx = rand_coord(3); r.dy = rand_coord(2); r.dz = $urandom_range(0, 1) ? 1 : -1;
      end
      pending_rays.push_back(r);
    end
  endtask

  initial begin
    box_lo = '{0, 0, 0};
    box_hi = '{65536, 65536, 65536};
    epsilon = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rays against the default unit box.
    pending_rays.push_back('{32'hfffe0000, 32'h8000, 32'h8000, 32'h10000, 0, 0});
    pending_rays.push_back('{32'h30000, 32'h8000, 32'h8000, 32'hffff0000, 0, 0});
    pending_rays.push_back('{32'h8000, 32'hfffe0000, 32'h8000, 0, 32'h10000, 0});
    pending_rays.push_back('{32'h8000, 32'h30000, 32'h8000, 0, 32'hffff0000, 0});
    pending_rays.push_back('{32'h8000, 32'h8000, 32'hfffe0000, 0, 0, 32'h10000});
    pending_rays.push_back('{32'h8000, 32'h8000, 32'h30000, 0, 0, 32'hffff0000});
    pending_rays.push_back('{32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0});
    pending_rays.push_back('{32'hfffe0000, 32'hfffe0000, 32'hfffe0000,
                             32'h10000, 32'h10000, 32'h10000});
    pending_rays.push_back('{32'hfffe0000, 32'h8000, 32'h8000, 32'hffff0000, 0, 0});
    pending_rays.push_back('{32'h8000, 32'h8000, 32'h8000, 0, 0, 0});
    pending_rays.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h80000000});
    pending_rays.push_back('{32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    pending_rays.push_back('{32'hfffe0000, 32'h8000, 32'h8000, 1, 0, 0});
    pending_rays.push_back('{32'hfffe0000, 32'h8000, 32'h8000, 32'hffffffff, 1, 32'h80000000});
    pending_rays.push_back('{32'hffffffff, 32'h0, 32'h1, 32'h10000, 32'h10000, 0});
    drain();

    queue_random(300);
    // Stall the receiver long enough for the pipeline to back up.
    hold_count <= HOLD_CYCLES;
    drain();

    set_box(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff);
    queue_random(300);
    drain();

    set_box(32'hffff0000, 32'h0, 32'h4000, 32'h20000, 32'h8000, 32'h30000, 16'h0);
    queue_random(300);
    drain();

    // Inverted box and a mid epsilon.
    set_box(32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0, 16'h100);
    queue_random(100);
    drain();

    set_box(32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000, 16'h1);
    queue_random(200);
    stim_done = 1'b1;
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
